>>> sv/grpi_pkg.sv
// ----------------------------------------------------------------------------
// grpi_pkg
// Shared types and constants of the graph rank block: payload structs,
// action and status codes, datapath micro-operations, command and status.
// ----------------------------------------------------------------------------
package grpi_pkg;

  localparam int unsigned MAX_VERTICES    = 1024;
  localparam int unsigned VTX_W           = 10;
  localparam int unsigned VC_W            = 11;
  localparam int unsigned SCORE_FRAC_BITS = 30;
  localparam int unsigned SCORE_W         = 32;
  localparam int unsigned DAMP_W          = 16;
  localparam int unsigned ITER_W          = 16;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd3;

  localparam logic [VC_W-1:0]     VC_RESET    = 11'd1024;
  localparam logic [DAMP_W-1:0]   DAMP_RESET  = 16'd55706;
  localparam logic [SCORE_W-1:0]  TOL_RESET   = 32'd1074;
  localparam logic [ITER_W-1:0]   ITER_RESET  = 16'd1000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SCORE_W-1:0] score;
    logic [ITER_W-1:0]  iterations;
    logic               converged;
    logic [SCORE_W-1:0] final_error;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_CLR_ALL,
    OP_CLR_DEG,
    OP_IDX_CLR,
    OP_IDX_INC,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_READ_RD,
    OP_DIV_INIT,
    OP_DIV_BASE,
    OP_RUN_START,
    OP_SCORE_INIT,
    OP_ITER_START,
    OP_ACC_FILL,
    OP_EDGE_RD,
    OP_EDGE_VRD,
    OP_MUL,
    OP_DIV_EDGE,
    OP_ACC_WR,
    OP_SW_RD,
    OP_SW_WR,
    OP_ITER_END,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
    logic    use_score;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    load_range;
    logic    read_range;
    logic    full;
    logic    vtx_last;
    logic    clr_last;
    logic    edge_end;
    logic    edge_skip;
    logic    div_busy;
    logic    limit_zero;
    logic    iter_done;
    logic    conv;
  } dp_stat_t;

endpackage

>>> sv/grpi_div.sv
// ----------------------------------------------------------------------------
// grpi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grpi_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;
endmodule

>>> sv/grpi_ctrl.sv
// ----------------------------------------------------------------------------
// grpi_ctrl
// Sequencer: decodes requests and steps the datapath through loads, reads,
// clears and runs.
module grpi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  grpi_pkg::dp_stat_t stat_i,
  output grpi_pkg::dp_cmd_t  cmd_o
);
  import grpi_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DECODE, S_LOAD_WR, S_CLR_DEG, S_DIV1, S_DIV2, S_SINIT,
    S_ITER, S_FILL, S_EDGE0, S_EDGE_CHK, S_E_VRD, S_E_TEST, S_E_DIV, S_E_WAIT,
    S_SW_RD, S_SW_WR, S_ITER_END, S_ITER_CHK, S_RESULT
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  status_e status_q, status_d;
  logic    use_q, use_d;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    use_d       = use_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{op: OP_NOP, status: status_q, use_score: use_q};
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.op = OP_CLR_ALL;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = STATUS_OK;
        use_d    = 1'b0;
        unique case (stat_i.action)
          ACT_LOAD: begin
            if (stat_i.load_range) begin
              status_d = STATUS_RANGE;
              state_d  = S_RESULT;
            end else if (stat_i.full) begin
              status_d = STATUS_FULL;
              state_d  = S_RESULT;
            end else begin
              cmd_o.op = OP_LOAD_RD;
              state_d  = S_LOAD_WR;
            end
          end
          ACT_RUN: begin
            cmd_o.op = OP_DIV_INIT;
            state_d  = S_DIV1;
          end
          ACT_READ: begin
            if (stat_i.read_range) begin
              status_d = STATUS_RANGE;
            end else begin
              cmd_o.op = OP_READ_RD;
              use_d    = 1'b1;
            end
            state_d = S_RESULT;
          end
          ACT_CLEAR: begin
            cmd_o.op = OP_IDX_CLR;
            state_d  = S_CLR_DEG;
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_LOAD_WR: begin
        cmd_o.op = OP_LOAD_WR;
        state_d  = S_RESULT;
      end
      S_CLR_DEG: begin
        cmd_o.op = OP_CLR_DEG;
        if (stat_i.clr_last) state_d = S_RESULT;
      end
      S_DIV1: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_DIV_BASE;
          state_d  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_RUN_START;
          state_d  = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd_o.op = OP_SCORE_INIT;
        if (stat_i.vtx_last) state_d = stat_i.limit_zero ? S_RESULT : S_ITER;
      end
      S_ITER: begin
        cmd_o.op = OP_ITER_START;
        state_d  = S_FILL;
      end
      S_FILL: begin
        cmd_o.op = OP_ACC_FILL;
        if (stat_i.vtx_last) state_d = S_EDGE0;
      end
      S_EDGE0: begin
        cmd_o.op = OP_IDX_CLR;
        state_d  = S_EDGE_CHK;
      end
      S_EDGE_CHK: begin
        if (stat_i.edge_end) begin
          cmd_o.op = OP_IDX_CLR;
          state_d  = S_SW_RD;
        end else begin
          cmd_o.op = OP_EDGE_RD;
          state_d  = S_E_VRD;
        end
      end
      S_E_VRD: begin
        cmd_o.op = OP_EDGE_VRD;
        state_d  = S_E_TEST;
      end
      S_E_TEST: begin
        if (stat_i.edge_skip) begin
          cmd_o.op = OP_IDX_INC;
          state_d  = S_EDGE_CHK;
        end else begin
          cmd_o.op = OP_MUL;
          state_d  = S_E_DIV;
        end
      end
      S_E_DIV: begin
        cmd_o.op = OP_DIV_EDGE;
        state_d  = S_E_WAIT;
      end
      S_E_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ACC_WR;
          state_d  = S_EDGE_CHK;
        end
      end
      S_SW_RD: begin
        cmd_o.op = OP_SW_RD;
        state_d  = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.op = OP_SW_WR;
        state_d  = stat_i.vtx_last ? S_ITER_END : S_SW_RD;
      end
      S_ITER_END: begin
        cmd_o.op = OP_ITER_END;
        state_d  = S_ITER_CHK;
      end
      S_ITER_CHK: begin
        state_d = (stat_i.conv || stat_i.iter_done) ? S_RESULT : S_ITER;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      use_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      use_q       <= use_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
endmodule

>>> sv/grpi_dp.sv
// ----------------------------------------------------------------------------
// grpi_dp
// Datapath: configuration, edge store, degree/score/accumulator memories,
// damping multiplier, shared divider and the result register.
// ----------------------------------------------------------------------------
module grpi_dp #(
  parameter int unsigned MAX_EDGES = 8192
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [grpi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [grpi_pkg::CFG_W-1:0]       cfg_data_i,
  input  grpi_pkg::in_t                    in_data_i,
  input  grpi_pkg::dp_cmd_t                cmd_i,
  output grpi_pkg::dp_stat_t               stat_o,
  output grpi_pkg::out_t                   out_data_o
);
  import grpi_pkg::*;

  localparam int unsigned EC_W   = $clog2(MAX_EDGES + 1);
  localparam int unsigned EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned DEN_W  = (EC_W > VC_W) ? EC_W : VC_W;
  localparam int unsigned IDX_W  = DEN_W;
  localparam int unsigned BASE_SH = SCORE_FRAC_BITS - DAMP_W;
  localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(64'd1 << SCORE_FRAC_BITS);

  // configuration
  logic [VC_W-1:0]    vc_q;
  logic [DAMP_W-1:0]  damp_q;
  logic [SCORE_W-1:0] tol_q;
  logic [ITER_W-1:0]  maxit_q;

  // control counters and run results
  logic [IDX_W-1:0]   idx_q;
  logic [EC_W-1:0]    ecount_q;
  logic [ITER_W-1:0]  iter_q, last_iter_q;
  logic [SCORE_W-1:0] last_err_q;
  logic               conv_q;

  // payload registers
  in_t                item_q;
  logic [SCORE_W-1:0] err_q, init_q, base_q, prod_q;
  logic [VTX_W-1:0]   esrc_q, etgt_q;
  logic [EC_W-1:0]    deg_rd_q;
  logic [SCORE_W-1:0] score_rd_q, acc_rd_q;
  out_t               out_q;

  // memories
  logic [VTX_W-1:0]   esrc_mem [MAX_EDGES];
  logic [VTX_W-1:0]   etgt_mem [MAX_EDGES];
  logic [EC_W-1:0]    deg_mem  [MAX_VERTICES];
  logic [SCORE_W-1:0] score_mem[MAX_VERTICES];
  logic [SCORE_W-1:0] acc_mem  [MAX_VERTICES];

  logic [VC_W-1:0]    n_eff;
  logic [VTX_W-1:0]   vidx;
  logic               div_start, div_busy;
  logic [SCORE_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0]   div_den;
  logic [DAMP_W:0]    damp_comp;
  logic [2*SCORE_W-1:0] prod_full;
  logic [SCORE_W:0]   acc_sum, err_sum;
  logic [SCORE_W-1:0] acc_new, diff;

  logic               deg_we, deg_re, sc_we, sc_re, acc_we, acc_re, edge_we, edge_re;
  logic [VTX_W-1:0]   deg_wa, deg_ra, sc_wa, sc_ra, acc_wa, acc_ra;
  logic [EC_W-1:0]    deg_wd;
  logic [SCORE_W-1:0] sc_wd, acc_wd;

  assign n_eff = (vc_q == '0) ? VC_W'(1) :
                 (vc_q > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vc_q;
  assign vidx  = idx_q[VTX_W-1:0];

  // arithmetic
  assign damp_comp = (DAMP_W+1)'(1 << DAMP_W) - {1'b0, damp_q};
  assign prod_full = (2*SCORE_W)'(damp_q) * (2*SCORE_W)'(score_rd_q);
  assign acc_sum   = {1'b0, acc_rd_q} + {1'b0, div_quo};
  assign acc_new   = acc_sum[SCORE_W] ? '1 : acc_sum[SCORE_W-1:0];
  assign diff      = (acc_rd_q >= score_rd_q) ? acc_rd_q - score_rd_q
                                              : score_rd_q - acc_rd_q;
  assign err_sum   = {1'b0, err_q} + {1'b0, diff};

  assign div_start = cmd_i.op inside {OP_DIV_INIT, OP_DIV_BASE, OP_DIV_EDGE};

  always_comb begin
    div_num = prod_q;
    div_den = DEN_W'(deg_rd_q);
    if (cmd_i.op == OP_DIV_INIT) begin
      div_num = SCORE_ONE;
      div_den = DEN_W'(n_eff);
    end else if (cmd_i.op == OP_DIV_BASE) begin
      div_num = SCORE_W'(damp_comp) << BASE_SH;
      div_den = DEN_W'(n_eff);
    end
  end

  grpi_div #(.NUM_W(SCORE_W), .DEN_W(DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // memory port selection
  always_comb begin
    deg_we = 1'b0; deg_re = 1'b0; deg_wa = vidx; deg_ra = esrc_q; deg_wd = '0;
    sc_we = 1'b0;  sc_re = 1'b0;  sc_wa = vidx;  sc_ra = vidx;  sc_wd = '0;
    acc_we = 1'b0; acc_re = 1'b0; acc_wa = vidx; acc_ra = vidx; acc_wd = base_q;
    edge_we = 1'b0; edge_re = 1'b0;
    unique case (cmd_i.op)
      OP_CLR_ALL: begin
        deg_we = 1'b1;
        sc_we  = 1'b1;
      end
      OP_CLR_DEG:    deg_we = 1'b1;
      OP_LOAD_RD: begin
        deg_re = 1'b1;
        deg_ra = item_q.src_vertex;
      end
      OP_LOAD_WR: begin
        edge_we = 1'b1;
        deg_we  = 1'b1;
        deg_wa  = item_q.src_vertex;
        deg_wd  = deg_rd_q + EC_W'(1);
      end
      OP_READ_RD: begin
        sc_re = 1'b1;
        sc_ra = item_q.dst_vertex;
      end
      OP_SCORE_INIT: begin
        sc_we = 1'b1;
        sc_wd = init_q;
      end
      OP_ACC_FILL:   acc_we = 1'b1;
      OP_EDGE_RD:    edge_re = 1'b1;
      OP_EDGE_VRD: begin
        deg_re = 1'b1;
        sc_re  = 1'b1;
        sc_ra  = esrc_q;
        acc_re = 1'b1;
        acc_ra = etgt_q;
      end
      OP_ACC_WR: begin
        acc_we = 1'b1;
        acc_wa = etgt_q;
        acc_wd = acc_new;
      end
      OP_SW_RD: begin
        sc_re  = 1'b1;
        acc_re = 1'b1;
      end
      OP_SW_WR: begin
        sc_we = 1'b1;
        sc_wd = acc_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (deg_re) deg_rd_q <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) score_mem[sc_wa] <= sc_wd;
    if (sc_re) score_rd_q <= score_mem[sc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    if (acc_re) acc_rd_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      esrc_mem[ecount_q[EA_W-1:0]] <= item_q.src_vertex;
      etgt_mem[ecount_q[EA_W-1:0]] <= item_q.dst_vertex;
    end
    if (edge_re) begin
      esrc_q <= esrc_mem[idx_q[EA_W-1:0]];
      etgt_q <= etgt_mem[idx_q[EA_W-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VC_RESET;
      damp_q      <= DAMP_RESET;
      tol_q       <= TOL_RESET;
      maxit_q     <= ITER_RESET;
      idx_q       <= '0;
      ecount_q    <= '0;
      iter_q      <= '0;
      last_iter_q <= '0;
      last_err_q  <= '0;
      conv_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VERTEX_COUNT:   vc_q    <= cfg_data_i[VC_W-1:0];
          CFG_DAMPING:        damp_q  <= cfg_data_i[DAMP_W-1:0];
          CFG_TOLERANCE:      tol_q   <= cfg_data_i[SCORE_W-1:0];
          CFG_MAX_ITERATIONS: maxit_q <= cfg_data_i[ITER_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op) inside
        OP_CLR_ALL, OP_SCORE_INIT, OP_ACC_FILL, OP_IDX_INC, OP_ACC_WR, OP_SW_WR:
          idx_q <= idx_q + IDX_W'(1);
        OP_CLR_DEG: begin
          idx_q    <= idx_q + IDX_W'(1);
          ecount_q <= '0;
        end
        OP_IDX_CLR, OP_ITER_START: idx_q <= '0;
        OP_LOAD_WR: ecount_q <= ecount_q + EC_W'(1);
        OP_RUN_START: begin
          idx_q       <= '0;
          iter_q      <= '0;
          last_iter_q <= '0;
          last_err_q  <= '0;
          conv_q      <= 1'b0;
        end
        OP_ITER_END: begin
          iter_q      <= iter_q + ITER_W'(1);
          last_iter_q <= iter_q + ITER_W'(1);
          last_err_q  <= err_q;
          conv_q      <= err_q < tol_q;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE:    item_q <= in_data_i;
      OP_DIV_BASE:   init_q <= div_quo;
      OP_RUN_START:  base_q <= div_quo;
      OP_ITER_START: err_q  <= '0;
      OP_MUL:        prod_q <= prod_full[SCORE_W+DAMP_W-1:DAMP_W];
      OP_SW_WR:      err_q  <= err_sum[SCORE_W] ? '1 : err_sum[SCORE_W-1:0];
      OP_RESULT: begin
        out_q.status      <= cmd_i.status;
        out_q.score       <= cmd_i.use_score ? score_rd_q : '0;
        out_q.iterations  <= last_iter_q;
        out_q.converged   <= conv_q;
        out_q.final_error <= last_err_q;
      end
      default: ;
    endcase
  end

  assign stat_o.action     = action_e'(item_q.action);
  assign stat_o.load_range = (VC_W'(item_q.src_vertex) >= n_eff) ||
                             (VC_W'(item_q.dst_vertex) >= n_eff);
  assign stat_o.read_range = VC_W'(item_q.dst_vertex) >= n_eff;
  assign stat_o.full       = ecount_q == EC_W'(MAX_EDGES);
  assign stat_o.vtx_last   = idx_q == IDX_W'(n_eff - VC_W'(1));
  assign stat_o.clr_last   = idx_q == IDX_W'(MAX_VERTICES - 1);
  assign stat_o.edge_end   = idx_q >= IDX_W'(ecount_q);
  assign stat_o.edge_skip  = (VC_W'(esrc_q) >= n_eff) || (VC_W'(etgt_q) >= n_eff) ||
                             (deg_rd_q == '0);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.limit_zero = maxit_q == '0;
  assign stat_o.iter_done  = iter_q == maxit_q;
  assign stat_o.conv       = conv_q;

  assign out_data_o = out_q;
endmodule

>>> sv/graph_rank_power_iteration_top.sv
// ----------------------------------------------------------------------------
// graph_rank_power_iteration_top
// Fixed-point rank by power iteration over a stored directed edge list.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_ready_o   grpi_pkg::in_t  in_data_i
//   out      from block out_valid_o / out_ready_i grpi_pkg::out_t out_data_o
//   cfg      to block   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One request is worked at a time. A run makes its two start divisions on
// the shared divider and sets the starting scores, then per iteration fills
// the accumulators, walks the edge list, dividing each contributing edge's
// share on the same divider, and sweeps the new scores in. After reset a
// sweep clears degrees and scores; no request is taken until it ends. A
// finished result waits in the output register while the next request is
// accepted.
// ----------------------------------------------------------------------------
module graph_rank_power_iteration_top #(
  parameter int unsigned MAX_EDGES = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grpi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grpi_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  grpi_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output grpi_pkg::out_t                 out_data_o
);
  import grpi_pkg::*;

  // controller steps the datapath with one micro-operation per cycle
  dp_cmd_t  cmd;
  dp_stat_t stat;

  grpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, arithmetic and the held result live here
  grpi_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );
endmodule

>>> sv/grpi_checker.sv
// ----------------------------------------------------------------------------
// grpi_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module grpi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input grpi_pkg::out_t out_data_o
);
  import grpi_pkg::*;

  hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  no_bad_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  score_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |-> out_data_o.score == '0)
    else $error("score on failed request");

  no_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.iterations == '0 |->
      !out_data_o.converged && out_data_o.final_error == '0)
    else $error("run state without iterations");
endmodule

bind graph_rank_power_iteration_top grpi_checker u_grpi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> verif/graph_rank_power_iteration_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_rank_power_iteration_check
// Watches the request, result and register ports of the graph rank block. It
// keeps its own copy of the edge list, degrees and scores, works out the
// result of each accepted request and compares it with the block's results.
// ----------------------------------------------------------------------------
module graph_rank_power_iteration_check #(
  parameter int unsigned MAX_EDGES = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grpi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [grpi_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  grpi_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  grpi_pkg::out_t                 out_data_i,
  output int                             pending_o,
  output int                             errors_o
);
  import grpi_pkg::*;

  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;

  logic [VC_W-1:0]    vtx_count_q;
  logic [DAMP_W-1:0]  damping_q;
  logic [SCORE_W-1:0] tol_q;
  logic [ITER_W-1:0]  iter_limit_q;

  logic [VTX_W-1:0] edge_src [MAX_EDGES];
  logic [VTX_W-1:0] edge_dst [MAX_EDGES];
  int unsigned      edge_cnt;
  int unsigned      degree [MAX_VERTICES];
  longint unsigned  rank [MAX_VERTICES];
  longint unsigned  acc [MAX_VERTICES];
  logic [ITER_W-1:0]  last_iters;
  logic [SCORE_W-1:0] last_err;
  logic               last_conv;

  out_t expected_results [$];

  function automatic int unsigned active_vertices();
    if (vtx_count_q == 0) return 1;
    if (vtx_count_q > MAX_VERTICES) return MAX_VERTICES;
    return 32'(vtx_count_q);
  endfunction

  // One full power-iteration run over the stored edges.
  task automatic rank_run();
    int unsigned n;
    longint unsigned d, base, init, c, sum, diff, err;
    int unsigned s, t;
    n    = active_vertices();
    d    = 64'(damping_q);
    base = ((64'd1 << (SCORE_FRAC_BITS - 16)) * (65536 - d)) / n;
    init = (64'd1 << SCORE_FRAC_BITS) / n;
    for (int v = 0; v < n; v++) rank[v] = init;
    last_iters = '0;
    last_err   = '0;
    last_conv  = 1'b0;
    for (int it = 0; it < iter_limit_q; it++) begin
      err = 0;
      for (int v = 0; v < n; v++) acc[v] = base;
      for (int e = 0; e < edge_cnt; e++) begin
        s = 32'(edge_src[e]);
        t = 32'(edge_dst[e]);
        if (s >= n || t >= n || degree[s] == 0) continue;
        c = (d * (rank[s] >> 16) + ((d * (rank[s] & 64'hFFFF)) >> 16)) / degree[s];
        sum = acc[t] + c;
        if (sum > SAT32) sum = SAT32;
        acc[t] = sum;
      end
      for (int v = 0; v < n; v++) begin
        diff = acc[v] > rank[v] ? acc[v] - rank[v] : rank[v] - acc[v];
        if (diff > SAT32 - err) err = SAT32;
        else err += diff;
        rank[v] = acc[v];
      end
      last_iters = ITER_W'(it + 1);
      last_err   = err[31:0];
      if (err < tol_q) begin
        last_conv = 1'b1;
        break;
      end
    end
  endtask

  task automatic predict_request(input in_t req);
    out_t        res;
    int unsigned n;
    n   = active_vertices();
    res = '0;
    res.status = STATUS_OK;
    case (action_e'(req.action))
      ACT_LOAD: begin
        if (req.src_vertex >= n || req.dst_vertex >= n) begin
          res.status = STATUS_RANGE;
        end else if (edge_cnt >= MAX_EDGES) begin
          res.status = STATUS_FULL;
        end else begin
          edge_src[edge_cnt] = req.src_vertex;
          edge_dst[edge_cnt] = req.dst_vertex;
          edge_cnt++;
          degree[req.src_vertex]++;
        end
      end
      ACT_RUN: rank_run();
      ACT_READ: begin
        if (req.dst_vertex >= n) res.status = STATUS_RANGE;
        else res.score = rank[req.dst_vertex][31:0];
      end
      default: begin
        edge_cnt = 0;
        for (int v = 0; v < MAX_VERTICES; v++) degree[v] = 0;
      end
    endcase
    res.iterations  = last_iters;
    res.converged   = last_conv;
    res.final_error = last_err;
    expected_results = {expected_results, res};
  endtask

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
    errors_o++;
  endtask

  // Return the model to its state after reset.
  task automatic reset_model();
    errors_o     = 0;
    pending_o    = 0;
    vtx_count_q  = VC_RESET;
    damping_q    = DAMP_RESET;
    tol_q        = TOL_RESET;
    iter_limit_q = ITER_RESET;
    edge_cnt     = 0;
    last_iters   = '0;
    last_err     = '0;
    last_conv    = 1'b0;
    expected_results.delete();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      degree[v] = 0;
      rank[v]   = 0;
      acc[v]    = 0;
    end
  endtask

  always @(posedge clk_i) begin
    out_t got, want;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VERTEX_COUNT:   vtx_count_q  = cfg_data_i[VC_W-1:0];
          CFG_DAMPING:        damping_q    = cfg_data_i[DAMP_W-1:0];
          CFG_TOLERANCE:      tol_q        = cfg_data_i[SCORE_W-1:0];
          CFG_MAX_ITERATIONS: iter_limit_q = cfg_data_i[ITER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(got.final_error), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
          if (got.score !== want.score)
            report("score", 64'(got.score), 64'(want.score));
          if (got.iterations !== want.iterations)
            report("iterations", 64'(got.iterations), 64'(want.iterations));
          if (got.converged !== want.converged)
            report("converged", 64'(got.converged), 64'(want.converged));
          if (got.final_error !== want.final_error)
            report("final_error", 64'(got.final_error), 64'(want.final_error));
        end
      end
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      pending_o = expected_results.size();
    end
  end

endmodule

>>> verif/graph_rank_power_iteration_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_rank_power_iteration_top_test
// Drives load, run, read and clear requests and register writes into the
// graph rank block under random idling on both sides; a checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module graph_rank_power_iteration_top_test;
  import grpi_pkg::*;

  localparam int unsigned EDGE_DEPTH = 8192;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;

  int pending;
  int errors;
  bit steady;       // when set, both sides drop their idle gaps
  int random_sent;

  graph_rank_power_iteration_top #(
    .MAX_EDGES(EDGE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  graph_rank_power_iteration_check #(
    .MAX_EDGES(EDGE_DEPTH)
  ) i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Send one request. Called at a falling edge and returns at a falling edge
  // right after the request was taken; valid stays high across back-to-back
  // requests so it is never lowered and raised in the same step.
  task automatic send_request(input action_e act, input int unsigned src,
                              input int unsigned dst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_data_i.action     <= act;
    in_data_i.src_vertex <= src[VTX_W-1:0];
    in_data_i.dst_vertex <= dst[VTX_W-1:0];
    // ready is stable during the low phase; high here means taken at next rise
    #1;
    while (!in_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
  endtask

  // Drop valid right after the last taken request, hold off until every
  // outstanding result has come back, then let the block settle before any
  // register write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(input int unsigned n, input int unsigned d,
                          input int unsigned tol, input int unsigned iters);
    wait_idle();
    write_reg(CFG_VERTEX_COUNT, n);
    write_reg(CFG_DAMPING, d);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITERATIONS, iters);
  endtask

  // Result side: draw a stall per result, then accept.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      int stall;
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      #1;
      while (!out_valid_o) begin
        @(negedge clk_i);
        #1;
      end
      @(negedge clk_i);
    end
  end

  initial begin
    #200ms;
    $display("[graph_rank_power_iteration_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned n, k, tol, d;
    steady      = 1'b0;
    random_sent = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset registers, empty graph converges on the second iteration.
    send_request(ACT_READ, 0, 0);
    send_request(ACT_RUN, 0, 0);
    send_request(ACT_READ, 0, 1023);
    send_request(ACT_LOAD, 1023, 1023);
    send_request(ACT_LOAD, 0, 1023);
    send_request(ACT_CLEAR, 0, 0);

    // Zero vertex count acts as one vertex.
    set_regs(0, 0, 0, 3);
    send_request(ACT_LOAD, 0, 0);
    send_request(ACT_LOAD, 1, 0);
    send_request(ACT_LOAD, 0, 1);
    send_request(ACT_RUN, 0, 0);
    send_request(ACT_READ, 0, 0);
    send_request(ACT_READ, 0, 1);

    // Oversized count, full damping, widest tolerance and limit.
    set_regs(2047, 65535, 32'hFFFF_FFFF, 65535);
    send_request(ACT_RUN, 0, 0);
    send_request(ACT_READ, 0, 512);
    send_request(ACT_CLEAR, 0, 0);

    // Zero iteration limit only sets the starting scores.
    set_regs(3, 32768, 100, 0);
    send_request(ACT_LOAD, 2, 1);
    send_request(ACT_RUN, 0, 0);
    send_request(ACT_READ, 0, 2);

    // Edges beyond a shrunk vertex count are skipped.
    set_regs(8, 55706, 1074, 6);
    send_request(ACT_LOAD, 7, 0);
    send_request(ACT_LOAD, 0, 7);
    send_request(ACT_LOAD, 1, 0);
    set_regs(4, 55706, 1074, 6);
    send_request(ACT_RUN, 0, 0);
    send_request(ACT_READ, 0, 0);

    // Random phases: new registers, a small graph, runs and reads, noise.
    while (random_sent < 75) begin
      steady = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: d = 0;
        1: d = 65535;
        default: d = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = 32'hFFFF_FFFF;
        2: tol = $urandom_range(0, 4000);
        default: tol = $urandom();
      endcase
      set_regs(n, d, tol, $urandom_range(0, 12));
      send_request(ACT_CLEAR, 0, 0);
      random_sent++;
      if (n == 0) n = 1;
      if (n > 1024) n = 1024;
      k = (n > 16) ? $urandom_range(0, 3) : $urandom_range(1, 24);
      for (int e = 0; e < k; e++) begin
        if ($urandom_range(0, 7) == 0)
          send_request(ACT_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          send_request(ACT_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        random_sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        // shrink the vertex count so stored edges fall outside
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, $urandom_range(1, n));
      end
      send_request(ACT_RUN, 0, 0);
      random_sent++;
      repeat ($urandom_range(1, 4)) begin
        send_request(ACT_READ, $urandom_range(0, 1023),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, n - 1));
        random_sent++;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("[graph_rank_power_iteration_top] OK");
    end else begin
      $display("[graph_rank_power_iteration_top] ERROR");
    end
    $finish;
  end

endmodule
